// File: rtl/core/plateau_peak_detector_defines.svh
// Assertion macros for the plateau peak detector checker
`ifndef PLATEAU_PEAK_DETECTOR_DEFINES_SVH
`define PLATEAU_PEAK_DETECTOR_DEFINES_SVH

// Checked only while out of reset
`define PPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("plateau_peak_detector assertion failed");

// Checked at every edge, reset included
`define PPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("plateau_peak_detector assertion failed");

`endif

// File: rtl/core/ppd_pkg.sv
// Shared types and constants of the plateau peak detector
`timescale 1ns / 1ps

package ppd_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic closed;   // a flat top was closed by a lower sample
        logic last;     // word carried the frame end mark
    } ev_flags_t;

    localparam int FLAG_BITS = $bits(ev_flags_t);

endpackage

// File: rtl/core/plateau_peak_detector.sv
// Top level of the plateau peak detector
// The event for a result word is queued when its word is accepted, then moved to the output register.
// Throughput: one input word per cycle while the event queue is not full; the two-entry
// event queue and the output register let input and output stall independently.
// Reset (aresetn low, synchronous): frame state, queue and output valid flag cleared,
// min_height returns to 0.
`timescale 1ns / 1ps

module plateau_peak_detector #(
    parameter int INDEX_BITS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // min_height
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] peak_index, [31:16] peak value
    output logic        m_axis_tuser,   // peak_valid
    output logic        m_axis_tlast    // frame_end
);

    localparam int SW = (SAMPLE_BITS < ppd_pkg::FIELD_BITS) ? SAMPLE_BITS
                        : ppd_pkg::FIELD_BITS;
    localparam int EV_BITS = ppd_pkg::FLAG_BITS + SW + 2 * INDEX_BITS;

    logic                  in_accept;
    logic                  ev_push, q_full, q_pop, q_not_empty;
    ppd_pkg::ev_flags_t    f_flags, b_flags;
    logic [SW-1:0]         f_value, b_value;
    logic [INDEX_BITS-1:0] f_start, b_start, f_right, b_right;
    logic [EV_BITS-1:0]    q_in, q_out;
    logic [15:0]           out_index, out_value;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    ppd_front #(
        .INDEX_BITS (INDEX_BITS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_sample   (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .ev_push     (ev_push),
        .ev_flags    (f_flags),
        .ev_value    (f_value),
        .ev_top_start(f_start),
        .ev_right    (f_right)
    );

    assign q_in = {f_flags, f_value, f_start, f_right};

    ppd_queue #(
        .DATA_BITS(EV_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (ev_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_out)
    );

    assign {b_flags, b_value, b_start, b_right} = q_out;

    ppd_back #(
        .INDEX_BITS (INDEX_BITS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ev_valid    (q_not_empty),
        .ev_pop      (q_pop),
        .ev_flags    (b_flags),
        .ev_value    (b_value),
        .ev_top_start(b_start),
        .ev_right    (b_right),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_index   (out_index),
        .out_value   (out_value),
        .out_peak    (m_axis_tuser),
        .out_end     (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_index};

endmodule

// File: rtl/core/ppd_front.sv
// Front end: accepts samples, tracks the flat top and emits close/frame-end events
`timescale 1ns / 1ps

module ppd_front #(
    parameter int INDEX_BITS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_accept,
    input  logic [ppd_pkg::FIELD_BITS-1:0]         in_sample,
    input  logic                                   in_last,
    output logic                                   ev_push,
    output ppd_pkg::ev_flags_t                     ev_flags,
    output logic [((SAMPLE_BITS < ppd_pkg::FIELD_BITS) ? SAMPLE_BITS
                   : ppd_pkg::FIELD_BITS)-1:0]     ev_value,
    output logic [INDEX_BITS-1:0]                  ev_top_start,
    output logic [INDEX_BITS-1:0]                  ev_right
);

    localparam int SW = (SAMPLE_BITS < ppd_pkg::FIELD_BITS) ? SAMPLE_BITS
                        : ppd_pkg::FIELD_BITS;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    logic [SW-1:0]         prev_reg, prev_next;
    logic [INDEX_BITS-1:0] count_reg, count_next;
    logic [INDEX_BITS-1:0] top_start_reg, top_start_next;
    logic                  top_open_reg, top_open_next;

    logic [SW-1:0] s;
    logic          started;
    logic          closes;
    logic          rises;

    assign s       = in_sample[SW-1:0];
    assign started = (count_reg != '0);
    assign closes  = started && top_open_reg && (s < prev_reg);
    assign rises   = started && (s > prev_reg);

    always_comb begin
        prev_next      = s;
        top_start_next = rises ? count_reg : top_start_reg;
        top_open_next  = top_open_reg;
        if (closes) begin
            top_open_next = 1'b0;
        end else if (rises) begin
            top_open_next = 1'b1;
        end
        count_next = (count_reg != IDX_MAX) ? count_reg + INDEX_BITS'(1) : count_reg;
        if (in_last) begin
            count_next    = '0;
            top_open_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            count_reg     <= '0;
            top_start_reg <= '0;
            top_open_reg  <= 1'b0;
        end else if (in_accept) begin
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            top_start_reg <= top_start_next;
            top_open_reg  <= top_open_next;
        end
    end

    assign ev_push         = in_accept && (closes || in_last);
    assign ev_flags.closed = closes;
    assign ev_flags.last   = in_last;
    assign ev_value        = prev_reg;
    assign ev_top_start    = top_start_reg;
    assign ev_right        = count_reg - INDEX_BITS'(1);

endmodule

// File: rtl/core/ppd_queue.sv
// Short event queue between front and back end
`timescale 1ns / 1ps

module ppd_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output logic [DATA_BITS-1:0] pop_data
);

    localparam int PTR_BITS = (ppd_pkg::QUEUE_DEPTH > 1) ? $clog2(ppd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(ppd_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(ppd_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(ppd_pkg::QUEUE_DEPTH);

    logic [DATA_BITS-1:0] entry_reg [ppd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/ppd_back.sv
// Back end: midpoint, height threshold and the output register
`timescale 1ns / 1ps

module ppd_back #(
    parameter int INDEX_BITS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ppd_pkg::FIELD_BITS-1:0]         cfg_wr_data,
    input  logic                                   ev_valid,
    output logic                                   ev_pop,
    input  ppd_pkg::ev_flags_t                     ev_flags,
    input  logic [((SAMPLE_BITS < ppd_pkg::FIELD_BITS) ? SAMPLE_BITS
                   : ppd_pkg::FIELD_BITS)-1:0]     ev_value,
    input  logic [INDEX_BITS-1:0]                  ev_top_start,
    input  logic [INDEX_BITS-1:0]                  ev_right,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ppd_pkg::FIELD_BITS-1:0]         out_index,
    output logic [ppd_pkg::FIELD_BITS-1:0]         out_value,
    output logic                                   out_peak,
    output logic                                   out_end
);

    logic [ppd_pkg::FIELD_BITS-1:0] min_height_reg;
    logic                           valid_reg, valid_next;
    logic [ppd_pkg::FIELD_BITS-1:0] index_reg, index_next;
    logic [ppd_pkg::FIELD_BITS-1:0] value_reg, value_next;
    logic                           peak_reg, peak_next;
    logic                           end_reg, end_next;

    logic [INDEX_BITS:0]            sum;
    logic [ppd_pkg::FIELD_BITS-1:0] value16;
    logic                           found;

    assign ev_pop  = ev_valid && (!valid_reg || out_ready);
    assign sum     = {1'b0, ev_top_start} + {1'b0, ev_right};
    assign value16 = ppd_pkg::FIELD_BITS'(ev_value);
    assign found   = ev_flags.closed && (value16 >= min_height_reg);

    always_comb begin
        valid_next = valid_reg;
        index_next = index_reg;
        value_next = value_reg;
        peak_next  = peak_reg;
        end_next   = end_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (ev_pop) begin
            valid_next = found || ev_flags.last;
            index_next = found ? ppd_pkg::FIELD_BITS'(sum[INDEX_BITS:1]) : '0;
            value_next = found ? value16 : '0;
            peak_next  = found;
            end_next   = ev_flags.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_height_reg <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_height_reg <= cfg_wr_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg <= index_next;
        value_reg <= value_next;
        peak_reg  <= peak_next;
        end_reg   <= end_next;
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_value = value_reg;
    assign out_peak  = peak_reg;
    assign out_end   = end_reg;

endmodule

// File: rtl/core/ppd_checker.sv
// Port-level checker for the plateau peak detector and its bind
`timescale 1ns / 1ps
`include "plateau_peak_detector_defines.svh"

module ppd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast
);

    logic        out_stall;
    logic        no_peak;
    logic [33:0] out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign no_peak   = m_axis_tvalid && !m_axis_tuser;
    assign out_word  = {m_axis_tdata, m_axis_tuser, m_axis_tlast};

    // stalled result word holds
    `PPD_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_axis_tvalid && $stable(out_word))

    // a word without a peak is only ever the frame end
    `PPD_ASSERT(a_nopeak_is_end, aclk, aresetn, no_peak |-> m_axis_tlast)

    // a word without a peak carries zero index and value
    `PPD_ASSERT(a_nopeak_zero, aclk, aresetn, no_peak |-> m_axis_tdata == 32'd0)

    // reset empties the output register
    `PPD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_axis_tvalid)

endmodule

bind plateau_peak_detector ppd_checker u_ppd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
